@@ sv/node_partition_detector_unit_macros.svh @@
// Assertion macros for the node partition detector.
// Included by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef NODE_PARTITION_DETECTOR_UNIT_MACROS_SVH
`define NODE_PARTITION_DETECTOR_UNIT_MACROS_SVH
`ifndef SYNTH
// cond holds in the same cycle as trig
`define NPD_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("npd check failed");
// cond holds in the cycle after trig
`define NPD_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("npd check failed");
`else
`define NPD_ASSERT_NOW(label, trig, cond)
`define NPD_ASSERT_NEXT(label, trig, cond)
`endif
`endif

@@ sv/npd_pkg.sv @@
// Shared types and constants for the node partition detector.
// No dependencies; used by the interfaces, the update logic and the top level.
package npd_pkg;

    localparam int ID_W       = 6;
    localparam int PORT_TIME_W = 48;
    localparam int MISS_W     = 16;
    localparam int CNT_W      = 32;
    localparam int TIMEOUT_W  = 32;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 32'd1000000;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_node_state;

    localparam t_cmd CMD_CHECK   = 2'd0;
    localparam t_cmd CMD_CONTACT = 2'd1;
    localparam t_cmd CMD_RECOVER = 2'd2;

    localparam t_node_state ST_CONNECTED = 2'd0;
    localparam t_node_state ST_SUSPECTED = 2'd1;
    localparam t_node_state ST_CONFIRMED = 2'd2;
    localparam t_node_state ST_RECOVERED = 2'd3;

    // side effects of one request on the table and counters
    typedef struct packed {
        logic wr;        // entry word is written back
        logic create;    // entry is new: set its valid bit
        logic present;   // entry exists after the request
        logic confirm;   // node moved to confirmed
        logic recover;   // node marked recovered
        logic not_found; // recover on a node without entry
    } t_upd_flags;

endpackage

@@ sv/npd_cmd_if.sv @@
// Request channel of the node partition detector.
// Depends on npd_pkg for field widths.
interface npd_cmd_if;
    logic                              valid;
    logic                              ready;
    npd_pkg::t_cmd                     cmd;
    logic [npd_pkg::ID_W-1:0]          node_id;
    logic [npd_pkg::PORT_TIME_W-1:0]   now_ticks;
    logic [npd_pkg::PORT_TIME_W-1:0]   peer_time;

    modport source (output valid, cmd, node_id, now_ticks, peer_time, input ready);
    modport sink   (input valid, cmd, node_id, now_ticks, peer_time, output ready);
endinterface

@@ sv/npd_res_if.sv @@
// Result channel of the node partition detector.
// Depends on npd_pkg for field widths.
interface npd_res_if;
    logic                          valid;
    logic                          ready;
    npd_pkg::t_node_state          node_state;
    logic                          just_confirmed;
    logic                          not_found;
    logic [npd_pkg::MISS_W-1:0]    missed_count;
    logic [npd_pkg::CNT_W-1:0]     detected_total;
    logic [npd_pkg::CNT_W-1:0]     recovered_total;

    modport source (output valid, node_state, just_confirmed, not_found, missed_count,
                    detected_total, recovered_total, input ready);
    modport sink   (input valid, node_state, just_confirmed, not_found, missed_count,
                    detected_total, recovered_total, output ready);
endinterface

@@ sv/npd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module npd_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/npd_update.sv @@
// Read-modify-write logic for one table entry: next entry fields and side-effect flags.
// Depends on npd_pkg for codes and the flag struct.
module npd_update #(
    parameter int TW = 48
) (
    input  npd_pkg::t_cmd                   i_cmd,
    input  logic                            i_in_range,
    input  logic                            i_present,
    input  npd_pkg::t_node_state            i_state,
    input  logic [TW-1:0]                   i_last,
    input  logic [TW-1:0]                   i_det,
    input  logic [npd_pkg::MISS_W-1:0]      i_missed,
    input  logic [TW-1:0]                   i_now,
    input  logic [TW-1:0]                   i_peer,
    input  logic [npd_pkg::TIMEOUT_W-1:0]   i_timeout,
    output npd_pkg::t_node_state            o_state,
    output logic [TW-1:0]                   o_last,
    output logic [TW-1:0]                   o_det,
    output logic [npd_pkg::MISS_W-1:0]      o_missed,
    output npd_pkg::t_upd_flags             o_flags
);

    localparam int CW = (TW > npd_pkg::TIMEOUT_W) ? TW : npd_pkg::TIMEOUT_W;

    logic [TW-1:0] ref_time;
    logic [TW:0]   diff;
    logic          late;

    // reference is the last contact, or the detection time when none was recorded
    assign ref_time = (i_last != '0) ? i_last : i_det;
    assign diff     = {1'b0, i_now} - {1'b0, ref_time};
    assign late     = !diff[TW] && (CW'(diff[TW-1:0]) >= CW'(i_timeout));

    always_comb begin
        o_state = i_state;
        o_last  = i_last;
        o_det   = i_det;
        o_missed = i_missed;
        o_flags = '0;
        o_flags.present = i_in_range && i_present;
        case (i_cmd)
            npd_pkg::CMD_CHECK: begin
                if (i_in_range && !i_present) begin
                    o_state  = npd_pkg::ST_CONNECTED;
                    o_det    = i_now;
                    o_last   = '0;
                    o_missed = '0;
                    o_flags.wr = 1'b1;
                    o_flags.create = 1'b1;
                    o_flags.present = 1'b1;
                end else if (i_in_range && i_state != npd_pkg::ST_RECOVERED && late) begin
                    o_flags.wr = 1'b1;
                    if (i_missed != '1) begin
                        o_missed = i_missed + 1'b1;
                    end
                    if (i_state == npd_pkg::ST_CONNECTED) begin
                        o_state = npd_pkg::ST_SUSPECTED;
                        o_det   = i_now;
                    end else if (i_state == npd_pkg::ST_SUSPECTED) begin
                        o_state = npd_pkg::ST_CONFIRMED;
                        o_det   = i_now;
                        o_flags.confirm = 1'b1;
                    end
                end
            end
            npd_pkg::CMD_CONTACT: begin
                if (i_in_range) begin
                    o_flags.wr = 1'b1;
                    o_flags.present = 1'b1;
                    o_last = i_peer;
                    if (!i_present) begin
                        o_state  = npd_pkg::ST_CONNECTED;
                        o_det    = i_now;
                        o_missed = '0;
                        o_flags.create = 1'b1;
                    end else if (i_state == npd_pkg::ST_SUSPECTED ||
                                 i_state == npd_pkg::ST_CONFIRMED) begin
                        o_state  = npd_pkg::ST_CONNECTED;
                        o_missed = '0;
                    end
                end
            end
            npd_pkg::CMD_RECOVER: begin
                if (i_in_range && i_present) begin
                    o_state = npd_pkg::ST_RECOVERED;
                    o_flags.wr = 1'b1;
                    o_flags.recover = 1'b1;
                end else begin
                    o_flags.not_found = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ sv/node_partition_detector_unit.sv @@
// Top level of the node partition detector: request stage, entry tables, result register.
// Depends on npd_pkg, npd_cmd_if, npd_res_if, npd_ram, npd_update and the macros header.
//
// Heartbeat-timeout failure detector over a table of NODE_COUNT nodes. One request is taken
// per clock cycle while results are drained; its result passes the request stage into the
// output register. A result left waiting holds the request stage, and with it the input.
// The table lives in two RAMs with registered read data: a valid-bit RAM and an entry RAM
// (state, last contact, detection time, missed count). A request reads its entry when it is
// accepted and writes it back as it leaves the request stage; a request accepted in the
// cycle its node is written back takes the write-back data from a bypass register. After
// reset, a clearing pass zeroes the valid bits of all NODE_COUNT entries, and no request is
// taken until it ends; the timeout register may be written during that pass.
`include "node_partition_detector_unit_macros.svh"

module node_partition_detector_unit #(
    parameter int NODE_COUNT = 64,
    parameter int TIME_BITS  = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [npd_pkg::TIMEOUT_W-1:0]   i_cfg_wdata,
    npd_cmd_if.sink                         i_cmd,
    npd_res_if.source                       o_res
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int TW = (TIME_BITS < npd_pkg::PORT_TIME_W) ? TIME_BITS : npd_pkg::PORT_TIME_W;
    localparam int MW = npd_pkg::MISS_W;
    localparam int EW = 2 + 2 * TW + MW;
    localparam logic [AW-1:0] LAST_IDX = AW'(NODE_COUNT - 1);

    // configuration
    logic [npd_pkg::TIMEOUT_W-1:0] r_timeout;

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_idx;

    // request stage
    logic            r_s1_v;
    npd_pkg::t_cmd   r_s1_cmd;
    logic [AW-1:0]   r_s1_idx;
    logic            r_s1_in_range;
    logic [TW-1:0]   r_s1_now;
    logic [TW-1:0]   r_s1_peer;

    // bypass of the last write-back
    logic            r_fwd_v;
    logic [AW-1:0]   r_fwd_idx;
    logic [EW-1:0]   r_fwd_entry;

    // counters
    logic [npd_pkg::CNT_W-1:0] r_conf;
    logic [npd_pkg::CNT_W-1:0] r_rec;
    logic [npd_pkg::CNT_W-1:0] n_conf;
    logic [npd_pkg::CNT_W-1:0] n_rec;

    // result register
    logic                       r_o_v;
    npd_pkg::t_node_state       r_o_state;
    logic                       r_o_newly;
    logic                       r_o_nf;
    logic [MW-1:0]              r_o_missed;
    logic [npd_pkg::CNT_W-1:0]  r_o_det;
    logic [npd_pkg::CNT_W-1:0]  r_o_rec;

    logic          in_accept;
    logic          s1_fire;
    logic          in_range;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] ram_entry;
    logic [0:0]    ram_valid;
    logic          fwd_hit;
    logic [EW-1:0] cur_entry;
    logic          cur_valid;
    logic          vram_we;
    logic [AW-1:0] vram_waddr;
    logic [0:0]    vram_wdata;
    logic          eram_we;
    logic [EW-1:0] new_entry;

    npd_pkg::t_node_state    new_state;
    logic [TW-1:0]           new_last;
    logic [TW-1:0]           new_det;
    logic [MW-1:0]           new_missed;
    npd_pkg::t_upd_flags     flags;

    assign s1_fire   = r_s1_v && (!r_o_v || o_res.ready);
    assign i_cmd.ready = !r_clr_busy && (!r_s1_v || s1_fire);
    assign in_accept = i_cmd.valid && i_cmd.ready;
    assign in_range  = 32'(i_cmd.node_id) < 32'(NODE_COUNT);

    // a stalled request re-reads its own entry so the RAM output stays current
    assign rd_addr = in_accept ? AW'(i_cmd.node_id) : r_s1_idx;

    assign fwd_hit   = r_fwd_v && (r_fwd_idx == r_s1_idx);
    assign cur_entry = fwd_hit ? r_fwd_entry : ram_entry;
    assign cur_valid = fwd_hit || ram_valid[0];

    npd_update #(
        .TW (TW)
    ) u_update (
        .i_cmd      (r_s1_cmd),
        .i_in_range (r_s1_in_range),
        .i_present  (cur_valid),
        .i_state    (cur_entry[EW-1 -: 2]),
        .i_last     (cur_entry[EW-3 -: TW]),
        .i_det      (cur_entry[EW-3-TW -: TW]),
        .i_missed   (cur_entry[MW-1:0]),
        .i_now      (r_s1_now),
        .i_peer     (r_s1_peer),
        .i_timeout  (r_timeout),
        .o_state    (new_state),
        .o_last     (new_last),
        .o_det      (new_det),
        .o_missed   (new_missed),
        .o_flags    (flags)
    );

    assign new_entry = {new_state, new_last, new_det, new_missed};
    assign eram_we   = s1_fire && flags.wr;

    assign vram_we    = r_clr_busy || (s1_fire && flags.create);
    assign vram_waddr = r_clr_busy ? r_clr_idx : r_s1_idx;
    assign vram_wdata = r_clr_busy ? 1'b0 : 1'b1;

    npd_ram #(
        .W     (1),
        .DEPTH (NODE_COUNT)
    ) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (vram_waddr),
        .i_wdata (vram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_valid)
    );

    npd_ram #(
        .W     (EW),
        .DEPTH (NODE_COUNT)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (eram_we),
        .i_waddr (r_s1_idx),
        .i_wdata (new_entry),
        .i_raddr (rd_addr),
        .o_rdata (ram_entry)
    );

    always_comb begin
        n_conf = r_conf;
        n_rec  = r_rec;
        if (s1_fire && flags.confirm && r_conf != '1) begin
            n_conf = r_conf + 1'b1;
        end
        if (s1_fire && flags.recover && r_rec != '1) begin
            n_rec = r_rec + 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= npd_pkg::TIMEOUT_RST;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_s1_v     <= 1'b0;
            r_fwd_v    <= 1'b0;
            r_conf     <= '0;
            r_rec      <= '0;
            r_o_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
            r_fwd_v <= eram_we;
            r_conf  <= n_conf;
            r_rec   <= n_rec;
            if (s1_fire) begin
                r_o_v <= 1'b1;
            end else if (o_res.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd      <= i_cmd.cmd;
            r_s1_idx      <= AW'(i_cmd.node_id);
            r_s1_in_range <= in_range;
            r_s1_now      <= TW'(i_cmd.now_ticks);
            r_s1_peer     <= TW'(i_cmd.peer_time);
        end
        if (eram_we) begin
            r_fwd_idx   <= r_s1_idx;
            r_fwd_entry <= new_entry;
        end
        if (s1_fire) begin
            r_o_state  <= flags.present ? new_state : npd_pkg::ST_CONNECTED;
            r_o_missed <= flags.present ? new_missed : '0;
            r_o_newly  <= flags.confirm;
            r_o_nf     <= flags.not_found;
            r_o_det    <= n_conf;
            r_o_rec    <= n_rec;
        end
    end

    assign o_res.valid           = r_o_v;
    assign o_res.node_state      = r_o_state;
    assign o_res.just_confirmed  = r_o_newly;
    assign o_res.not_found       = r_o_nf;
    assign o_res.missed_count    = r_o_missed;
    assign o_res.detected_total  = r_o_det;
    assign o_res.recovered_total = r_o_rec;

    `NPD_ASSERT_NOW(a_no_accept_while_clearing, r_clr_busy, !in_accept)
    `NPD_ASSERT_NEXT(a_fire_fills_result, s1_fire, r_o_v)
    `NPD_ASSERT_NOW(a_newly_is_confirmed, r_o_v && r_o_newly, r_o_state == npd_pkg::ST_CONFIRMED)
    `NPD_ASSERT_NOW(a_not_found_is_empty, r_o_v && r_o_nf,
                    r_o_state == npd_pkg::ST_CONNECTED && r_o_missed == '0 && !r_o_newly)

endmodule

@@ tb/sv/node_partition_detector_unit_test.sv @@
// Self-checking bench for node_partition_detector_unit: directed and random requests,
// a liveness-table predictor and an in-order result scoreboard.
// Depends on npd_pkg, npd_cmd_if, npd_res_if and the RTL of the block.
module node_partition_detector_unit_test;

    localparam int NODES = 64;
    localparam int TW    = npd_pkg::PORT_TIME_W;
    localparam int LIMIT = 200000;

    localparam npd_pkg::t_cmd CMD_NOP = 2'd3;

    typedef struct packed {
        npd_pkg::t_cmd                op;
        logic [npd_pkg::ID_W-1:0]     node;
        logic [TW-1:0]                now;
        logic [TW-1:0]                peer;
    } t_request;

    typedef struct packed {
        npd_pkg::t_node_state         st;
        logic                         conf;
        logic                         nf;
        logic [npd_pkg::MISS_W-1:0]   miss;
        logic [npd_pkg::CNT_W-1:0]    det;
        logic [npd_pkg::CNT_W-1:0]    rec;
    } t_verdict;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [npd_pkg::TIMEOUT_W-1:0]   i_cfg_wdata;

    npd_cmd_if cmd_bus ();
    npd_res_if res_bus ();

    node_partition_detector_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd_bus),
        .o_res       (res_bus)
    );

    // predicted liveness table
    logic                           node_live    [NODES];
    npd_pkg::t_node_state           node_st      [NODES];
    logic [TW-1:0]                  node_contact [NODES];
    logic [TW-1:0]                  node_seen    [NODES];
    logic [npd_pkg::MISS_W-1:0]     node_misses  [NODES];
    logic [npd_pkg::CNT_W-1:0]      confirm_total;
    logic [npd_pkg::CNT_W-1:0]      recover_total;
    logic [npd_pkg::TIMEOUT_W-1:0]  timeout_reg;

    t_request pending   [$];
    t_verdict verdict_q [$];

    int   pushed;
    int   accepted;
    int   mismatch_cnt;
    int   cycle_cnt;
    int   hold_asks;
    int   hold_seen;
    int   hold_left;
    logic calm;
    logic req_taken;
    logic [TW-1:0] clock_now;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t %s: got %0h, want %0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic open_entry(input logic [npd_pkg::ID_W-1:0] id, input logic [TW-1:0] now,
                              input logic [TW-1:0] contact);
        node_live[id]    = 1'b1;
        node_st[id]      = npd_pkg::ST_CONNECTED;
        node_seen[id]    = now;
        node_contact[id] = contact;
        node_misses[id]  = '0;
    endtask

    // updates the predicted table for one request and returns the expected result
    task automatic apply_request(input t_request r, output t_verdict v);
        logic [TW-1:0] anchor;
        logic          hit;
        v   = '0;
        hit = node_live[r.node];
        case (r.op)
            npd_pkg::CMD_CHECK: begin
                if (!hit) begin
                    open_entry(r.node, r.now, '0);
                end else if (node_st[r.node] != npd_pkg::ST_RECOVERED) begin
                    // no recorded contact: measure from the detection time
                    anchor = (node_contact[r.node] != '0) ? node_contact[r.node]
                                                          : node_seen[r.node];
                    if (r.now >= anchor && (r.now - anchor) >= TW'(timeout_reg)) begin
                        if (node_misses[r.node] != '1)
                            node_misses[r.node] = node_misses[r.node] + 1'b1;
                        if (node_st[r.node] == npd_pkg::ST_CONNECTED) begin
                            node_st[r.node]   = npd_pkg::ST_SUSPECTED;
                            node_seen[r.node] = r.now;
                        end else if (node_st[r.node] == npd_pkg::ST_SUSPECTED) begin
                            node_st[r.node]   = npd_pkg::ST_CONFIRMED;
                            node_seen[r.node] = r.now;
                            v.conf = 1'b1;
                            if (confirm_total != '1)
                                confirm_total = confirm_total + 1'b1;
                        end
                    end
                end
            end
            npd_pkg::CMD_CONTACT: begin
                if (!hit) begin
                    open_entry(r.node, r.now, r.peer);
                end else begin
                    node_contact[r.node] = r.peer;
                    if (node_st[r.node] == npd_pkg::ST_SUSPECTED ||
                        node_st[r.node] == npd_pkg::ST_CONFIRMED) begin
                        node_st[r.node]     = npd_pkg::ST_CONNECTED;
                        node_misses[r.node] = '0;
                    end
                end
            end
            npd_pkg::CMD_RECOVER: begin
                if (!hit) begin
                    v.nf = 1'b1;
                end else begin
                    node_st[r.node] = npd_pkg::ST_RECOVERED;
                    if (recover_total != '1)
                        recover_total = recover_total + 1'b1;
                end
            end
            default: ;
        endcase
        v.st   = node_live[r.node] ? node_st[r.node] : npd_pkg::ST_CONNECTED;
        v.miss = node_live[r.node] ? node_misses[r.node] : '0;
        v.det  = confirm_total;
        v.rec  = recover_total;
    endtask

    // request driver
    always @(negedge i_clk) begin : feed_requests
        t_request r;
        if (i_rst_n && (!cmd_bus.valid || req_taken)) begin
            if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 38)) begin
                r = pending.pop_front();
                cmd_bus.valid     <= 1'b1;
                cmd_bus.cmd       <= r.op;
                cmd_bus.node_id   <= r.node;
                cmd_bus.now_ticks <= r.now;
                cmd_bus.peer_time <= r.peer;
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold-off on request from the stimulus
    always @(negedge i_clk) begin : drain_results
        if (hold_seen != hold_asks) begin
            hold_seen     <= hold_asks;
            hold_left     <= 300;
            res_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= calm || ($urandom_range(0, 99) >= 38);
        end
    end

    always @(posedge i_clk) begin : watch_ports
        t_request req;
        t_verdict want;
        if (i_rst_n) begin
            if (i_cfg_we)
                timeout_reg = i_cfg_wdata;
            req_taken <= cmd_bus.valid && cmd_bus.ready;
            if (cmd_bus.valid && cmd_bus.ready) begin
                req.op   = cmd_bus.cmd;
                req.node = cmd_bus.node_id;
                req.now  = cmd_bus.now_ticks;
                req.peer = cmd_bus.peer_time;
                apply_request(req, want);
                verdict_q.insert(verdict_q.size(), want);
                accepted <= accepted + 1;
            end
            if (res_bus.valid && res_bus.ready) begin
                if (verdict_q.size() == 0) begin
                    flag_mismatch("result with nothing pending", 64'(res_bus.node_state), 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (res_bus.node_state !== want.st)
                        flag_mismatch("node_state", 64'(res_bus.node_state), 64'(want.st));
                    if (res_bus.just_confirmed !== want.conf)
                        flag_mismatch("just_confirmed", 64'(res_bus.just_confirmed),
                                      64'(want.conf));
                    if (res_bus.not_found !== want.nf)
                        flag_mismatch("not_found", 64'(res_bus.not_found), 64'(want.nf));
                    if (res_bus.missed_count !== want.miss)
                        flag_mismatch("missed_count", 64'(res_bus.missed_count), 64'(want.miss));
                    if (res_bus.detected_total !== want.det)
                        flag_mismatch("detected_total", 64'(res_bus.detected_total),
                                      64'(want.det));
                    if (res_bus.recovered_total !== want.rec)
                        flag_mismatch("recovered_total", 64'(res_bus.recovered_total),
                                      64'(want.rec));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_request(input npd_pkg::t_cmd op, input logic [npd_pkg::ID_W-1:0] node,
                               input logic [TW-1:0] now, input logic [TW-1:0] peer);
        t_request r;
        r.op   = op;
        r.node = node;
        r.now  = now;
        r.peer = peer;
        pending.insert(pending.size(), r);
        pushed++;
    endtask

    // mostly well-formed traffic on a window of eight nodes, time stepping around the timeout
    task automatic queue_random(input int count, input int hot_base, input logic [31:0] span);
        logic [63:0] stride;
        logic [63:0] back;
        logic [TW-1:0] peer;
        logic [npd_pkg::ID_W-1:0] node;
        int pick;
        for (int i = 0; i < count; i++) begin
            if (span == 0) begin
                stride = 64'($urandom_range(0, 2));
            end else begin
                stride = {32'd0, $urandom} % ({32'd0, span} / 4 + 64'd1);
                if ($urandom_range(0, 1) == 1)
                    stride = stride + {32'd0, span};
            end
            clock_now = clock_now + stride[TW-1:0];
            node = ($urandom_range(0, 99) < 85)
                ? npd_pkg::ID_W'(hot_base + $urandom_range(0, 7))
                : npd_pkg::ID_W'($urandom_range(0, NODES - 1));
            back = {32'd0, $urandom} % ({32'd0, span} / 2 + 64'd1);
            peer = ($urandom_range(0, 9) == 0) ? '0 : clock_now - back[TW-1:0];
            pick = $urandom_range(0, 99);
            if (pick < 62)
                add_request(npd_pkg::CMD_CHECK, node, clock_now, TW'($urandom));
            else if (pick < 86)
                add_request(npd_pkg::CMD_CONTACT, node, clock_now, peer);
            else if (pick < 88)
                add_request(npd_pkg::CMD_RECOVER, node, clock_now, TW'($urandom));
            else if (pick < 91)
                add_request(CMD_NOP, node, clock_now, peer);
            else
                add_request(npd_pkg::t_cmd'($urandom_range(0, 3)), npd_pkg::ID_W'($urandom),
                            TW'({$urandom, $urandom}), TW'({$urandom, $urandom}));
        end
    endtask

    task automatic settle();
        do @(negedge i_clk); while (accepted != pushed || verdict_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_timeout(input logic [npd_pkg::TIMEOUT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : run_test
        logic [31:0] span;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.cmd       = npd_pkg::CMD_CHECK;
        cmd_bus.node_id   = '0;
        cmd_bus.now_ticks = '0;
        cmd_bus.peer_time = '0;
        res_bus.ready     = 1'b0;
        for (int i = 0; i < NODES; i++)
            node_live[i] = 1'b0;
        confirm_total = '0;
        recover_total = '0;
        timeout_reg   = npd_pkg::TIMEOUT_RST;
        pushed        = 0;
        accepted      = 0;
        mismatch_cnt  = 0;
        cycle_cnt     = 0;
        hold_asks     = 0;
        hold_seen     = 0;
        hold_left     = 0;
        calm          = 1'b0;
        req_taken     = 1'b0;
        clock_now     = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset timeout: creation, both timeout steps, contact, recover
        @(posedge i_clk);
        add_request(npd_pkg::CMD_RECOVER, 6'd5, '0, '0);
        add_request(npd_pkg::CMD_CHECK,   6'd0, '0, '0);
        add_request(npd_pkg::CMD_CHECK,   6'd0, 48'd999999, '0);
        add_request(npd_pkg::CMD_CHECK,   6'd0, 48'd1000000, '0);
        add_request(npd_pkg::CMD_CHECK,   6'd0, 48'd2000000, '0);
        add_request(npd_pkg::CMD_CHECK,   6'd0, 48'd3000000, '0);
        add_request(npd_pkg::CMD_CONTACT, 6'd0, 48'd3000000, '0);    // zero peer: no contact
        add_request(npd_pkg::CMD_CHECK,   6'd0, 48'd2500000, '0);
        add_request(CMD_NOP,              6'd0, '0, '0);
        add_request(CMD_NOP,              6'd9, '1, '1);
        add_request(npd_pkg::CMD_CONTACT, 6'd63, '1, '1);
        add_request(npd_pkg::CMD_CHECK,   6'd63, '0, '0);             // now before reference
        add_request(npd_pkg::CMD_RECOVER, 6'd63, '0, '0);
        add_request(npd_pkg::CMD_CHECK,   6'd63, '1, '0);
        add_request(npd_pkg::CMD_CONTACT, 6'd63, '1, 48'd5);
        add_request(npd_pkg::CMD_RECOVER, 6'd63, '0, '0);             // counted again
        add_request(npd_pkg::CMD_CHECK,   6'd1, '1, '0);
        settle();

        set_timeout('0);
        @(posedge i_clk);
        add_request(npd_pkg::CMD_CHECK,   6'd1, '1, '0);
        add_request(npd_pkg::CMD_CHECK,   6'd1, 48'hFFFF_FFFF_FFFE, '0);
        add_request(npd_pkg::CMD_CHECK,   6'd1, '1, '0);
        add_request(npd_pkg::CMD_CONTACT, 6'd1, 48'd7, '0);
        settle();

        set_timeout('1);
        @(posedge i_clk);
        add_request(npd_pkg::CMD_CHECK, 6'd2, '0, '0);
        add_request(npd_pkg::CMD_CHECK, 6'd2, 48'hFFFF_FFFE, '0);
        add_request(npd_pkg::CMD_CHECK, 6'd2, 48'hFFFF_FFFF, '0);

        for (int p = 1; p <= 6; p++) begin
            settle();
            case (p)
                1: span = 32'd20;
                2: span = '0;
                3: span = npd_pkg::TIMEOUT_RST;
                4: span = $urandom;
                5: span = '1;
                default: span = 32'd3;
            endcase
            set_timeout(span);
            @(posedge i_clk);
            calm      <= (p == 3);
            clock_now  = (p % 2 == 0) ? TW'({$urandom, $urandom}) : '0;
            queue_random(170, 8 * p, span);
            // results back up while requests keep coming
            if (p == 1)
                hold_asks <= hold_asks + 1;
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (verdict_q.size() != 0)
            flag_mismatch("results never seen", 64'(verdict_q.size()), 0);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/npd_pkg.sv
sv/npd_cmd_if.sv
sv/npd_res_if.sv
sv/npd_ram.sv
sv/npd_update.sv
sv/node_partition_detector_unit.sv
tb/sv/node_partition_detector_unit_test.sv
